@@ src/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, constants and helpers for the first-fit free list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  // Free table size and derived widths
  localparam int unsigned MAX_FREE_BLOCKS = 16;
  localparam int unsigned IDX_W = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FREE_BLOCKS + 1);

  // Field widths
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 31;
  localparam int unsigned ENTRY_W = ADDR_W + LEN_W;

  // Header in front of every carved block
  localparam logic [ADDR_W-1:0] HEADER_BYTES = ADDR_W'(8);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = CFG_IDX_W'(1);

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_REUSED   = 3'd0,
    ST_EXTENDED = 3'd1,
    ST_FREED    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NO_HEAP  = 3'd4
  } status_e;

  // Physical slot of a table position counted from the head (circular)
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (IDX_W+1)'(MAX_FREE_BLOCKS)) begin
      sum = sum - (IDX_W+1)'(MAX_FREE_BLOCKS);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Step the head one slot back (toward a new head)
  function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] s);
    if (s == '0) begin
      return IDX_W'(MAX_FREE_BLOCKS - 1);
    end
    return s - IDX_W'(1);
  endfunction

  // Step the head one slot forward
  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
    if (s == IDX_W'(MAX_FREE_BLOCKS - 1)) begin
      return '0;
    end
    return s + IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ src/first_fit_free_list_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit
// First-fit heap allocator with a most-recently-freed free table in RAM.
// ----------------------------------------------------------------------------
// A free writes the block at the new head of a circular free table held in
// a single-port-read, single-port-write RAM, or drops it with a table-full
// status when all entries are in use. An allocate reads the table one entry
// per cycle from the head to find a fit; the entries in front of the hit are
// then moved back one place, one per cycle, before the head advances past
// the hole, and the last move waits for room in the output register. A miss
// extends the heap at the break pointer. Each item gives exactly one result;
// a result waits in the output register, and the next item is stalled until
// it is taken. Writing heap_base also reloads the break pointer; the free
// table is kept.
`default_nettype none

module first_fit_free_list_allocator_unit
  import ffa_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ADDR_W-1:0]    cfg_wdata_i,
  // input items
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 operation_i,
  input  wire logic [LEN_W-1:0]     request_bytes_i,
  input  wire logic [ADDR_W-1:0]    block_address_i,
  input  wire logic [LEN_W-1:0]     block_length_i,
  // result items
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [ADDR_W-1:0]         granted_address_o,
  output logic [LEN_W-1:0]          granted_length_o,
  output logic [2:0]                status_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_EXTEND
  } state_e;

  // Control state
  state_e            state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [ADDR_W-1:0] bp_q, bp_d;
  logic [ADDR_W-1:0] limit_q, limit_d;
  logic              out_valid_q, out_valid_d;

  // Payload registers
  logic [LEN_W-1:0]  req_q, req_d;
  logic [ADDR_W-1:0] hit_addr_q, hit_addr_d;
  logic [LEN_W-1:0]  hit_len_q, hit_len_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  status_e           out_st_q, out_st_d;

  // Free table RAM
  logic [ENTRY_W-1:0] mem [MAX_FREE_BLOCKS];
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] rd_q;

  logic [ADDR_W-1:0]  rd_addr;
  logic [LEN_W-1:0]   rd_len;
  logic               out_free;
  logic               in_acc;
  logic [ADDR_W:0]    end_addr;

  assign rd_addr  = rd_q[ENTRY_W-1:LEN_W];
  assign rd_len   = rd_q[LEN_W-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  // Take a new item only between allocations and with room for its result
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // End of a block carved at the break pointer, without wrap
  assign end_addr = {1'b0, bp_q} + {2'b00, req_q} + {1'b0, HEADER_BYTES};

  // Next-state and RAM access logic
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    pos_d       = pos_q;
    bp_d        = bp_q;
    limit_d     = limit_q;
    req_d       = req_q;
    hit_addr_d  = hit_addr_q;
    hit_len_d   = hit_len_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_addr_d  = out_addr_q;
    out_len_d   = out_len_q;
    out_st_d    = out_st_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    // Configuration writes
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HEAP_BASE:  bp_d    = cfg_wdata_i;
        CFG_HEAP_LIMIT: limit_d = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (operation_i == OP_FREE) begin
            out_valid_d = 1'b1;
            out_addr_d  = '0;
            out_len_d   = '0;
            if (count_q == CNT_W'(MAX_FREE_BLOCKS)) begin
              out_st_d = ST_FULL;
            end else begin
              // Push the block in front of the current head
              head_d    = slot_dec(head_q);
              mem_we    = 1'b1;
              mem_waddr = slot_dec(head_q);
              mem_wdata = {block_address_i, block_length_i};
              count_d   = count_q + CNT_W'(1);
              out_st_d  = ST_FREED;
            end
          end else begin
            req_d = request_bytes_i;
            if (count_q == '0) begin
              state_d = S_EXTEND;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = head_q;
              pos_d     = '0;
              state_d   = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (rd_len >= req_q) begin
          hit_addr_d = rd_addr;
          hit_len_d  = rd_len;
          if (pos_q == '0) begin
            // Hit at the head: just drop it
            if (out_free) begin
              head_d      = slot_inc(head_q);
              count_d     = count_q - CNT_W'(1);
              out_valid_d = 1'b1;
              out_addr_d  = rd_addr;
              out_len_d   = rd_len;
              out_st_d    = ST_REUSED;
              state_d     = S_IDLE;
            end
          end else begin
            // Start moving the entries in front of the hit back one place
            mem_re    = 1'b1;
            mem_raddr = slot_of(head_q, pos_q - IDX_W'(1));
            state_d   = S_SHIFT;
          end
        end else if ((CNT_W'(pos_q) + CNT_W'(1)) < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(head_q, pos_q + IDX_W'(1));
          pos_d     = pos_q + IDX_W'(1);
        end else begin
          state_d = S_EXTEND;
        end
      end

      S_SHIFT: begin
        // rd_q holds the entry one place in front of pos_q
        mem_we    = 1'b1;
        mem_waddr = slot_of(head_q, pos_q);
        mem_wdata = rd_q;
        if (pos_q == IDX_W'(1)) begin
          if (out_free) begin
            head_d      = slot_inc(head_q);
            count_d     = count_q - CNT_W'(1);
            out_valid_d = 1'b1;
            out_addr_d  = hit_addr_q;
            out_len_d   = hit_len_q;
            out_st_d    = ST_REUSED;
            state_d     = S_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = slot_of(head_q, pos_q - IDX_W'(2));
          pos_d     = pos_q - IDX_W'(1);
        end
      end

      S_EXTEND: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (end_addr > {1'b0, limit_q}) begin
            out_addr_d = '0;
            out_len_d  = '0;
            out_st_d   = ST_NO_HEAP;
          end else begin
            out_addr_d = bp_q + HEADER_BYTES;
            out_len_d  = req_q;
            out_st_d   = ST_EXTENDED;
            bp_d       = end_addr[ADDR_W-1:0];
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      bp_q        <= '0;
      limit_q     <= '1;
      out_valid_q <= 1'b0;
      req_q       <= '0;
      hit_addr_q  <= '0;
      hit_len_q   <= '0;
      out_addr_q  <= '0;
      out_len_q   <= '0;
      out_st_q    <= ST_REUSED;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      bp_q        <= bp_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
      req_q       <= req_d;
      hit_addr_q  <= hit_addr_d;
      hit_len_q   <= hit_len_d;
      out_addr_q  <= out_addr_d;
      out_len_q   <= out_len_d;
      out_st_q    <= out_st_d;
    end
  end

  // Free table RAM: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign granted_length_o  = out_len_q;
  assign status_o          = out_st_q;

endmodule

`default_nettype wire

@@ tb/first_fit_free_list_allocator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit_tb
// Self-checking bench for the first-fit heap allocator. A short directed table
// covers the reset settings, field extremes, reuse, heap extension, the
// out-of-heap and table-full codes and the zero request. It is followed by
// random phases under several heap_base/heap_limit settings. Each accepted
// result is checked in order against the table's grant or a behavioral model
// of the free table and the break pointer. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_unit_tb;
  import ffa_pkg::*;

  typedef struct {
    logic              op;
    logic [LEN_W-1:0]  req;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } heap_req_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    status_e           status;
  } grant_t;

  typedef struct {
    heap_req_t cmd;
    bit        typed;
    grant_t    want;
  } dir_row_t;

  typedef struct {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] limit;
    int unsigned       items;
    int unsigned       free_pct;
    bit                calm;
  } heap_phase_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [ADDR_W-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 operation_i;
  logic [LEN_W-1:0]     request_bytes_i;
  logic [ADDR_W-1:0]    block_address_i;
  logic [LEN_W-1:0]     block_length_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [ADDR_W-1:0]    granted_address_o;
  logic [LEN_W-1:0]     granted_length_o;
  logic [2:0]           status_o;

  // Model state: break pointer, limit and the free table (entry 0 is the head)
  logic [ADDR_W-1:0] brk_ptr;
  logic [ADDR_W-1:0] limit_reg;
  logic [ADDR_W-1:0] free_addr [MAX_FREE_BLOCKS];
  logic [LEN_W-1:0]  free_len  [MAX_FREE_BLOCKS];
  int                free_cnt;

  grant_t      grant_q [$];
  grant_t      live_q  [$];
  int unsigned mismatches = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  first_fit_free_list_allocator_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .request_bytes_i   (request_bytes_i),
    .block_address_i   (block_address_i),
    .block_length_i    (block_length_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .granted_address_o (granted_address_o),
    .granted_length_o  (granted_length_o),
    .status_o          (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Apply one item to the model and return the grant it produces
  function automatic grant_t predict_grant(input heap_req_t r);
    grant_t         g;
    logic [ADDR_W:0] top;
    int             i;
    int             hit;
    g.addr   = '0;
    g.len    = '0;
    g.status = ST_FREED;
    hit      = -1;
    if (r.op == OP_ALLOC) begin
      // first fit from the head
      for (i = 0; i < free_cnt; i++) begin
        if (hit < 0 && free_len[i] >= r.req) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        g.addr   = free_addr[hit];
        g.len    = free_len[hit];
        g.status = ST_REUSED;
        for (i = hit; i + 1 < free_cnt; i++) begin
          free_addr[i] = free_addr[i+1];
          free_len[i]  = free_len[i+1];
        end
        free_cnt--;
      end else begin
        top = {1'b0, brk_ptr} + (ADDR_W+1)'(r.req) + (ADDR_W+1)'(HEADER_BYTES);
        if (top > {1'b0, limit_reg}) begin
          g.status = ST_NO_HEAP;
        end else begin
          g.addr   = brk_ptr + HEADER_BYTES;
          g.len    = r.req;
          g.status = ST_EXTENDED;
          brk_ptr  = top[ADDR_W-1:0];
        end
      end
    end else if (free_cnt >= MAX_FREE_BLOCKS) begin
      g.status = ST_FULL;
    end else begin
      // push the freed block in at the head
      for (i = free_cnt; i > 0; i--) begin
        free_addr[i] = free_addr[i-1];
        free_len[i]  = free_len[i-1];
      end
      free_addr[0] = r.addr;
      free_len[0]  = r.len;
      free_cnt++;
    end
    return g;
  endfunction

  // Mostly small sizes so that reuse hits, with zero and full-width ones mixed in
  function automatic logic [LEN_W-1:0] draw_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(255));
    endcase
  endfunction

  task automatic flag_result(input string why, input grant_t want, input grant_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected addr %h len %h status %0d, got addr %h len %h status %0d",
               $time, why, want.addr, want.len, want.status, got.addr, got.len, got.status);
    end
  endtask

  // Offer one item, hold it until accepted, then record the expected grant
  task automatic offer_item(input heap_req_t r, input bit typed, input grant_t want);
    grant_t g;
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= r.op;
    request_bytes_i <= r.req;
    block_address_i <= r.addr;
    block_length_i  <= r.len;
    do @(posedge clk_i); while (in_stall_o);
    g = predict_grant(r);
    if (typed) begin
      grant_q.push_back(want);
    end else begin
      grant_q.push_back(g);
    end
    if (g.status == ST_REUSED || g.status == ST_EXTENDED) begin
      live_q.push_back(g);
    end
  endtask

  // Drop valid and wait until every pending grant has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (grant_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Write both heap registers; heap_base also reloads the break pointer
  task automatic set_heap(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_HEAP_BASE;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_index_i <= CFG_HEAP_LIMIT;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    brk_ptr   = base;
    limit_reg = limit;
  endtask

  // Result side: random stall, plus one long hold-off to back the block up
  initial begin : sink
    int unsigned n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        for (n = 0; n < 300; n++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 19);
    end
  end

  // Compare each accepted result with the oldest pending grant
  always @(posedge clk_i) begin : check_grant
    grant_t want;
    grant_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.addr   = granted_address_o;
      got.len    = granted_length_o;
      got.status = status_e'(status_o);
      if (grant_q.size() == 0) begin
        flag_result("result with nothing pending", got, got);
      end else begin
        want = grant_q.pop_front();
        if (got.addr !== want.addr || got.len !== want.len || got.status !== want.status) begin
          flag_result("grant mismatch", want, got);
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t    dir_tab [$];
    heap_phase_t plan [$];
    heap_req_t   r;
    grant_t      none;
    int unsigned k;
    int unsigned n;
    int unsigned p;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= CFG_HEAP_BASE;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    operation_i     <= OP_ALLOC;
    request_bytes_i <= '0;
    block_address_i <= '0;
    block_length_i  <= '0;
    brk_ptr   = '0;
    limit_reg = '1;
    free_cnt  = 0;
    none      = '{'0, '0, ST_REUSED};

    // Directed rows; settings are still the reset ones (base 0, no limit)
    dir_tab.push_back('{'{OP_ALLOC, 31'd0, 32'd0, 31'd0}, 1'b1,
                        '{32'd8, 31'd0, ST_EXTENDED}});
    dir_tab.push_back('{'{OP_FREE, 31'd0, 32'h100, 31'd40}, 1'b1,
                        '{32'd0, 31'd0, ST_FREED}});
    dir_tab.push_back('{'{OP_FREE, 31'd0, 32'h200, 31'd8}, 1'b1,
                        '{32'd0, 31'd0, ST_FREED}});
    // first fit skips the too-short head
    dir_tab.push_back('{'{OP_ALLOC, 31'd20, 32'd0, 31'd0}, 1'b0, none});
    dir_tab.push_back('{'{OP_ALLOC, 31'h7FFF_FFFF, 32'd0, 31'd0}, 1'b1,
                        '{32'd16, 31'h7FFF_FFFF, ST_EXTENDED}});
    dir_tab.push_back('{'{OP_ALLOC, 31'h7FFF_FFFF, 32'd0, 31'd0}, 1'b1,
                        '{32'd0, 31'd0, ST_NO_HEAP}});
    dir_tab.push_back('{'{OP_FREE, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF}, 1'b1,
                        '{32'd0, 31'd0, ST_FREED}});
    dir_tab.push_back('{'{OP_ALLOC, 31'h7FFF_FFFF, 32'd0, 31'd0}, 1'b1,
                        '{32'hFFFF_FFFF, 31'h7FFF_FFFF, ST_REUSED}});
    // fill the table, then overflow it
    for (k = 0; k < MAX_FREE_BLOCKS - 1; k++) begin
      dir_tab.push_back('{'{OP_FREE, 31'd0, ADDR_W'(k * 32'h1000), LEN_W'(k * 16)}, 1'b1,
                          '{32'd0, 31'd0, ST_FREED}});
    end
    dir_tab.push_back('{'{OP_FREE, 31'd0, 32'hDEAD_0000, 31'd1}, 1'b1,
                        '{32'd0, 31'd0, ST_FULL}});
    // full scan with no fit, then the heap is out of room
    dir_tab.push_back('{'{OP_ALLOC, 31'h7FFF_FFF0, 32'd0, 31'd0}, 1'b1,
                        '{32'd0, 31'd0, ST_NO_HEAP}});
    // zero request takes the head
    dir_tab.push_back('{'{OP_ALLOC, 31'd0, 32'd0, 31'd0}, 1'b0, none});

    // Random phases: heap settings, length, share of frees, idling off
    plan.push_back('{32'h0000_1000, 32'h0010_0000, 250, 50, 1'b0});
    plan.push_back('{32'h0000_0000, 32'h0000_0000, 150, 40, 1'b0});
    plan.push_back('{32'hFFFF_FFF0, 32'hFFFF_FFFF, 150, 65, 1'b0});
    plan.push_back('{32'h8000_0000, 32'hFFFF_FFFF, 250, 50, 1'b1});
    plan.push_back('{32'hFFFF_FFFF, 32'h0000_0000, 100, 60, 1'b0});
    plan.push_back('{$urandom >> 2, $urandom, 300, 50, 1'b0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < dir_tab.size(); k++) begin
      offer_item(dir_tab[k].cmd, dir_tab[k].typed, dir_tab[k].want);
    end

    for (p = 0; p < plan.size(); p++) begin
      settle();
      quiet = plan[p].calm;
      set_heap(plan[p].base, plan[p].limit);
      for (n = 0; n < plan[p].items; n++) begin
        // back up the result side once while items keep coming
        if (p == 0 && n == 20) begin
          hold_req = 1'b1;
        end
        r.op   = ($urandom_range(99) < plan[p].free_pct) ? OP_FREE : OP_ALLOC;
        r.req  = draw_size();
        r.addr = $urandom;
        r.len  = draw_size();
        // mostly return blocks that were handed out, with their lengths
        if (r.op == OP_FREE && live_q.size() != 0 && $urandom_range(9) < 7) begin
          k = $urandom_range(live_q.size() - 1);
          r.addr = live_q[k].addr;
          r.len  = live_q[k].len;
          live_q.delete(k);
        end
        offer_item(r, 1'b0, none);
      end
    end

    settle();
    quiet = 1'b0;
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
